@@ rtl/core/dtmf_pkg.sv @@
// shared types, constants and sine table for the dual-tone synthesizer
`timescale 1ns / 1ps
`default_nettype none

package dtmf_pkg;

    localparam int unsigned STEP_W   = 32;
    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned NUM_ROWS = 4;
    localparam int unsigned NUM_COLS = 3;
    localparam int unsigned ROW_W    = $clog2(NUM_ROWS);
    localparam int unsigned COL_W    = $clog2(NUM_COLS);
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned ROM_DEPTH = 256;
    localparam int unsigned ROM_AW    = $clog2(ROM_DEPTH);

    localparam logic [SAMPLE_W-1:0] SILENT_LEVEL = 8'd128;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_KEY  = 2'd1,
        KIND_STOP = 2'd2
    } kind_t;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COL0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COL2 = 3'd6;

    localparam logic [STEP_W-1:0] ROW_STEP_RESET [NUM_ROWS] = '{
        32'd149679600, 32'd165356240, 32'd182965600, 32'd202078208
    };
    localparam logic [STEP_W-1:0] COL_STEP_RESET [NUM_COLS] = '{
        32'd259630768, 32'd286903808, 32'd317183328
    };

    typedef struct packed {
        logic             hit;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } key_pos_t;

    localparam logic [SAMPLE_W-1:0] SINE_ROM [ROM_DEPTH] = '{
        8'd128,8'd131,8'd134,8'd137,8'd140,8'd143,8'd146,8'd149,
        8'd152,8'd156,8'd159,8'd162,8'd165,8'd168,8'd171,8'd174,
        8'd176,8'd179,8'd182,8'd185,8'd188,8'd191,8'd193,8'd196,
        8'd199,8'd201,8'd204,8'd206,8'd209,8'd211,8'd213,8'd215,
        8'd218,8'd220,8'd222,8'd224,8'd226,8'd228,8'd230,8'd232,
        8'd234,8'd235,8'd237,8'd238,8'd240,8'd241,8'd243,8'd244,
        8'd245,8'd246,8'd247,8'd248,8'd249,8'd250,8'd251,8'd251,
        8'd252,8'd253,8'd253,8'd254,8'd254,8'd254,8'd254,8'd254,
        8'd255,8'd254,8'd254,8'd254,8'd254,8'd254,8'd254,8'd253,
        8'd253,8'd252,8'd251,8'd251,8'd250,8'd249,8'd248,8'd247,
        8'd246,8'd245,8'd244,8'd243,8'd241,8'd240,8'd238,8'd237,
        8'd235,8'd234,8'd232,8'd230,8'd228,8'd226,8'd224,8'd222,
        8'd220,8'd218,8'd215,8'd213,8'd211,8'd209,8'd206,8'd204,
        8'd201,8'd199,8'd196,8'd193,8'd191,8'd188,8'd185,8'd182,
        8'd179,8'd176,8'd174,8'd171,8'd168,8'd165,8'd162,8'd159,
        8'd156,8'd152,8'd149,8'd146,8'd143,8'd140,8'd137,8'd134,
        8'd131,8'd128,8'd124,8'd121,8'd118,8'd115,8'd112,8'd109,
        8'd106,8'd103,8'd99, 8'd96, 8'd93, 8'd90, 8'd87, 8'd84,
        8'd81, 8'd79, 8'd76, 8'd73, 8'd70, 8'd67, 8'd64, 8'd62,
        8'd59, 8'd56, 8'd54, 8'd51, 8'd49, 8'd46, 8'd44, 8'd42,
        8'd40, 8'd37, 8'd35, 8'd33, 8'd31, 8'd29, 8'd27, 8'd25,
        8'd23, 8'd21, 8'd20, 8'd18, 8'd17, 8'd15, 8'd14, 8'd12,
        8'd11, 8'd10, 8'd9,  8'd8,  8'd7,  8'd6,  8'd5,  8'd4,
        8'd4,  8'd3,  8'd2,  8'd2,  8'd1,  8'd1,  8'd1,  8'd1,
        8'd1,  8'd0,  8'd1,  8'd1,  8'd1,  8'd1,  8'd1,  8'd1,
        8'd2,  8'd2,  8'd3,  8'd4,  8'd4,  8'd5,  8'd6,  8'd7,
        8'd8,  8'd9,  8'd10, 8'd11, 8'd12, 8'd14, 8'd15, 8'd17,
        8'd18, 8'd20, 8'd21, 8'd23, 8'd25, 8'd27, 8'd29, 8'd31,
        8'd33, 8'd35, 8'd37, 8'd40, 8'd42, 8'd44, 8'd46, 8'd49,
        8'd51, 8'd54, 8'd56, 8'd59, 8'd62, 8'd64, 8'd67, 8'd70,
        8'd73, 8'd76, 8'd79, 8'd81, 8'd84, 8'd87, 8'd90, 8'd93,
        8'd96, 8'd99, 8'd103,8'd106,8'd109,8'd112,8'd115,8'd118
    };

endpackage

`default_nettype wire

@@ rtl/core/dtmf_dual_tone_synthesizer.sv @@
// top level: dual phase accumulator tone synthesizer with sine table
//
// Input channel (in_valid / in_stall) carries one item: kind and key_code.
//   tick  - advance both phases if a tone is on and emit one sample
//   key   - load row and column steps for a keypad key, no result
//   stop  - clear both steps, no result; other kinds are dropped
// Output channel (out_valid / out_stall) carries sample and tone_on, one
// result per tick; sample is 128 and tone_on low while silent.
// Config port: cfg_we writes cfg_data into step register cfg_index
// (rows 0..3, columns 4..6); write only while the block is idle.
// An item taken into the input register is worked from there into the
// result register; a stalled receiver holds a tick there. One item per
// cycle is sustained while no tick is held; the phase adds, the table
// reads and the average sit in the single stage between the two registers.
// Reset clears phases, active steps and both pipeline valid flags and
// loads the default step registers. While the receiver stalls, a held
// result stays put; key and stop items still pass, a tick waits in the
// input register and further input is stalled.
`timescale 1ns / 1ps
`default_nettype none

module dtmf_dual_tone_synthesizer
    import dtmf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [STEP_W-1:0]    cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           kind,
    input  wire logic [7:0]           key_code,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [SAMPLE_W-1:0]       sample,
    output logic                      tone_on
);

    logic [STEP_W-1:0]   row_steps_reg [NUM_ROWS];
    logic [STEP_W-1:0]   col_steps_reg [NUM_COLS];

    logic                stage_valid_reg;
    logic                stage_valid_next;
    logic [1:0]          stage_kind_reg;
    logic [7:0]          stage_key_reg;

    logic [STEP_W-1:0]   row_phase_reg, row_phase_next;
    logic [STEP_W-1:0]   col_phase_reg, col_phase_next;
    logic [STEP_W-1:0]   row_step_reg, row_step_next;
    logic [STEP_W-1:0]   col_step_reg, col_step_next;

    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                tone_on_reg, tone_on_next;

    logic                is_tick;
    logic                advance;
    logic                accept;
    logic                load_result;
    key_pos_t            key_pos;
    logic [SAMPLE_W-1:0] row_level, col_level;
    logic [SAMPLE_W:0]   level_sum;

    dtmf_key_decode u_key_decode (
        .key_code (stage_key_reg),
        .pos      (key_pos)
    );

    // a tick needs a free result slot, other kinds always move on
    assign is_tick     = (stage_kind_reg == KIND_TICK);
    assign advance     = stage_valid_reg && (!is_tick || !out_valid_reg || !out_stall);
    assign load_result = advance && is_tick;
    assign in_stall    = stage_valid_reg && !advance;
    assign accept      = in_valid && !in_stall;

    assign stage_valid_next = accept ? 1'b1 : (advance ? 1'b0 : stage_valid_reg);

    assign row_level = SINE_ROM[row_phase_next[STEP_W-1 -: ROM_AW]];
    assign col_level = SINE_ROM[col_phase_next[STEP_W-1 -: ROM_AW]];
    assign level_sum = {1'b0, row_level} + {1'b0, col_level};

    always_comb
    begin
        row_phase_next = row_phase_reg;
        col_phase_next = col_phase_reg;
        row_step_next  = row_step_reg;
        col_step_next  = col_step_reg;
        sample_next    = sample_reg;
        tone_on_next   = tone_on_reg;
        if (advance)
        begin
            case (stage_kind_reg)
                KIND_KEY:
                begin
                    if (key_pos.hit)
                    begin
                        row_step_next = row_steps_reg[key_pos.row];
                        col_step_next = col_steps_reg[key_pos.col];
                    end
                end
                KIND_STOP:
                begin
                    row_step_next = '0;
                    col_step_next = '0;
                end
                KIND_TICK:
                begin
                    if (row_step_reg != '0)
                    begin
                        row_phase_next = row_phase_reg + row_step_reg;
                        col_phase_next = col_phase_reg + col_step_reg;
                    end
                end
                default: ;
            endcase
        end
        if (load_result)
        begin
            if (row_step_reg != '0)
            begin
                sample_next  = level_sum[SAMPLE_W:1];
                tone_on_next = 1'b1;
            end
            else
            begin
                sample_next  = SILENT_LEVEL;
                tone_on_next = 1'b0;
            end
        end
    end

    assign out_valid_next = load_result ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ROWS; i++)
            begin
                row_steps_reg[i] <= ROW_STEP_RESET[i];
            end
            for (int i = 0; i < NUM_COLS; i++)
            begin
                col_steps_reg[i] <= COL_STEP_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index <= REG_ROW3)
            begin
                row_steps_reg[ROW_W'(cfg_index - REG_ROW0)] <= cfg_data;
            end
            else if (cfg_index <= REG_COL2)
            begin
                col_steps_reg[COL_W'(cfg_index - REG_COL0)] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            row_phase_reg   <= '0;
            col_phase_reg   <= '0;
            row_step_reg    <= '0;
            col_step_reg    <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            row_phase_reg   <= row_phase_next;
            col_phase_reg   <= col_phase_next;
            row_step_reg    <= row_step_next;
            col_step_reg    <= col_step_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_kind_reg <= kind;
            stage_key_reg  <= key_code;
        end
        sample_reg  <= sample_next;
        tone_on_reg <= tone_on_next;
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign tone_on   = tone_on_reg;

endmodule

`default_nettype wire

@@ rtl/core/dtmf_key_decode.sv @@
// keypad decoder: ascii key to row and column position
`timescale 1ns / 1ps
`default_nettype none

module dtmf_key_decode
    import dtmf_pkg::*;
(
    input  wire logic [7:0] key_code,
    output key_pos_t        pos
);

    always_comb
    begin
        pos = '0;
        unique case (key_code)
            "1": pos = '{hit: 1'b1, row: 2'd0, col: 2'd0};
            "2": pos = '{hit: 1'b1, row: 2'd0, col: 2'd1};
            "3": pos = '{hit: 1'b1, row: 2'd0, col: 2'd2};
            "4": pos = '{hit: 1'b1, row: 2'd1, col: 2'd0};
            "5": pos = '{hit: 1'b1, row: 2'd1, col: 2'd1};
            "6": pos = '{hit: 1'b1, row: 2'd1, col: 2'd2};
            "7": pos = '{hit: 1'b1, row: 2'd2, col: 2'd0};
            "8": pos = '{hit: 1'b1, row: 2'd2, col: 2'd1};
            "9": pos = '{hit: 1'b1, row: 2'd2, col: 2'd2};
            "*": pos = '{hit: 1'b1, row: 2'd3, col: 2'd0};
            "0": pos = '{hit: 1'b1, row: 2'd3, col: 2'd1};
            "#": pos = '{hit: 1'b1, row: 2'd3, col: 2'd2};
            default: pos = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/dtmf_checker.sv @@
// port level checks for the dual-tone synthesizer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module dtmf_checker
    import dtmf_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic [1:0]          kind,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire logic [SAMPLE_W-1:0] sample,
    input wire logic                tone_on
);

    // a held result stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(sample) && $stable(tone_on))
        else $error("result changed while stalled");

    // silence always shows the mid level
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tone_on |-> sample == SILENT_LEVEL)
        else $error("silent result with wrong level");

    // a new result follows a tick item accepted into the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && kind == KIND_TICK, 2))
        else $error("result without a tick item");

endmodule

bind dtmf_dual_tone_synthesizer dtmf_checker u_dtmf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample),
    .tone_on   (tone_on)
);

`default_nettype wire
